// ===== rtl/hsi_pkg.sv =====
// Shared types, constants and the low-pass coefficient table of the x3 interpolator.
// No dependencies; every other file but hsi_sum_tree.sv imports this package.
package hsi_pkg;

    localparam int SAMPLE_BITS     = 16;
    localparam int COEF_BITS       = 16;
    localparam int PROD_BITS       = SAMPLE_BITS + COEF_BITS;
    localparam int TAPS            = 43;
    localparam int TAP_IDX_W       = $clog2(TAPS);
    localparam int RATIO_DEF       = 3;
    localparam int EDGE_COPIES_DEF = 7;

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;
    typedef logic signed [COEF_BITS-1:0]   coef_t;
    typedef logic signed [PROD_BITS-1:0]   prod_t;

    typedef struct packed {
        logic shift;
        logic fill;
    } cell_ctrl_t;

    localparam coef_t COEF_ROM [TAPS] = '{
        16'sd0, 16'sd0, 16'sd0, 16'sd0, -16'sd18, -16'sd53, 16'sd24, 16'sd260,
        16'sd356, -16'sd85, -16'sd883, -16'sd1068, 16'sd166, 16'sd2101, 16'sd2502,
        -16'sd247, -16'sd4599, -16'sd5847, 16'sd306, 16'sd13305, 16'sd26733,
        16'sd32440, 16'sd26733, 16'sd13305, 16'sd306, -16'sd5847, -16'sd4599,
        -16'sd247, 16'sd2502, 16'sd2101, 16'sd166, -16'sd1068, -16'sd883,
        -16'sd85, 16'sd356, 16'sd260, 16'sd24, -16'sd53, -16'sd18,
        16'sd0, 16'sd0, 16'sd0, 16'sd0
    };

    function automatic coef_t coef_at(input int j);
        coef_t c;
        c = '0;
        if (j >= 0 && j < TAPS)
        begin
            c = COEF_ROM[j[TAP_IDX_W-1:0]];
        end
        return c;
    endfunction

endpackage

// ===== rtl/hsi_if.sv =====
// Valid/ready channel interfaces for input and output transactions.
// Depends on hsi_pkg.
interface hsi_in_if;
    import hsi_pkg::*;
    logic    valid;
    logic    ready;
    sample_t sample_in;
    logic    last_in;
    modport source (output valid, output sample_in, output last_in, input ready);
    modport sink   (input valid, input sample_in, input last_in, output ready);
endinterface

interface hsi_out_if;
    import hsi_pkg::*;
    logic    valid;
    logic    ready;
    sample_t sample_out;
    logic    clipped;
    logic    last_out;
    modport source (output valid, output sample_out, output clipped, output last_out,
                    input ready);
    modport sink   (input valid, input sample_out, input clipped, input last_out,
                    output ready);
endinterface

// ===== rtl/hsi_cell.sv =====
// One tap cell: holds one history sample, passes it to its neighbor, and
// registers its product with the coefficient of the current phase. Depends on hsi_pkg.
module hsi_cell #(
    parameter int RATIO = hsi_pkg::RATIO_DEF,
    parameter int M     = 0
) (
    input  logic                       clk,
    input  logic                       en,
    input  hsi_pkg::cell_ctrl_t        ctrl,
    input  hsi_pkg::sample_t           fill_value,
    input  hsi_pkg::sample_t           nbr_value,
    input  logic [$clog2(RATIO)-1:0]   phase,
    output hsi_pkg::sample_t           hist,
    output hsi_pkg::prod_t             prod
);
    import hsi_pkg::*;

    sample_t hist_reg;
    sample_t hist_next;
    coef_t   coef_sel;
    prod_t   prod_reg;

    always_comb
    begin
        if (ctrl.fill)
        begin
            hist_next = fill_value;
        end
        else if (ctrl.shift)
        begin
            hist_next = nbr_value;
        end
        else
        begin
            hist_next = hist_reg;
        end
        coef_sel = coef_at(RATIO * M - int'(phase));
    end

    always_ff @(posedge clk)
    begin
        hist_reg <= hist_next;
        if (en)
        begin
            prod_reg <= hist_reg * coef_sel;
        end
    end

    assign hist = hist_reg;
    assign prod = prod_reg;

endmodule

// ===== rtl/hsi_sum_tree.sv =====
// Registered binary adder tree over the cell products, with a register at every level.
// No package dependency.
module hsi_sum_tree #(
    parameter int N     = 15,
    parameter int IN_W  = 32,
    parameter int OUT_W = 36
) (
    input  logic                    clk,
    input  logic                    en,
    input  logic signed [IN_W-1:0]  leaf_in [N],
    output logic signed [OUT_W-1:0] sum
);
    localparam int LVL    = $clog2(N);
    localparam int LEAVES = 2 ** LVL;
    localparam int NODES  = LEAVES - 1;

    logic signed [OUT_W-1:0] leaf     [LEAVES];
    logic signed [OUT_W-1:0] node_reg [1:NODES];

    for (genvar k = 0; k < LEAVES; k++)
    begin : g_leaf
        if (k < N)
        begin : g_used
            assign leaf[k] = OUT_W'(leaf_in[k]);
        end
        else
        begin : g_pad
            assign leaf[k] = '0;
        end
    end

    for (genvar i = 1; i <= NODES; i++)
    begin : g_node
        if (2 * i >= LEAVES)
        begin : g_bottom
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    node_reg[i] <= leaf[2*i-LEAVES] + leaf[2*i+1-LEAVES];
                end
            end
        end
        else
        begin : g_inner
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    node_reg[i] <= node_reg[2*i] + node_reg[2*i+1];
                end
            end
        end
    end

    assign sum = node_reg[1];

endmodule

// ===== rtl/hann_sinc_interpolator_x3.sv =====
// Top level of the x3 windowed-sinc interpolator: issue control, tap cells,
// adder tree and round/saturate output stage. Depends on hsi_pkg, hsi_if, hsi_cell, hsi_sum_tree.
//
//   channel   dir   payload                         transaction
//   in_ch     in    sample_in, last_in              valid && ready
//   out_ch    out   sample_out, clipped, last_out   valid && ready
//
// Steady state: one output every cycle while out_ch accepts it; the cell row issues
// one phase of the shared tap window per cycle unless the output stalls, and loads
// the next input after the last phase of a group. last_in adds EDGE_COPIES flush steps,
// each issuing a group only with enough history; products, tree levels, output registered.
// Reset clears all control; a stalled output freezes the whole row while one more
// input transaction is still taken into the input buffer.
module hann_sinc_interpolator_x3 #(
    parameter int RATIO       = hsi_pkg::RATIO_DEF,
    parameter int EDGE_COPIES = hsi_pkg::EDGE_COPIES_DEF
) (
    input logic     clk,
    input logic     rst_n,
    hsi_in_if.sink    in_ch,
    hsi_out_if.source out_ch
);
    import hsi_pkg::*;

    localparam int WIN    = 2 * EDGE_COPIES + 1;
    localparam int LVL    = $clog2(WIN);
    localparam int ACC_W  = PROD_BITS + LVL;
    localparam int Q_W    = ACC_W - COEF_BITS + 2;
    localparam int PH_W   = $clog2(RATIO);
    localparam int FILL_W = $clog2(EDGE_COPIES + 2);
    localparam int FL_W   = $clog2(EDGE_COPIES + 1);
    localparam logic signed [ACC_W:0] HALF = (ACC_W + 1)'(2 ** (COEF_BITS - 2));

    logic              pend_valid_reg, pend_valid_next;
    sample_t           pend_sample_reg;
    logic              pend_last_reg;
    logic              started_reg, started_next;
    logic [FILL_W-1:0] fill_reg, fill_next, fill_inc;
    logic [FL_W-1:0]   flush_reg, flush_next;
    logic              grp_active_reg, grp_active_next;
    logic              grp_final_reg, grp_final_next;
    logic [PH_W-1:0]   phase_reg, phase_next;
    logic [LVL:0]      vld_pipe_reg;
    logic [LVL:0]      last_pipe_reg;
    logic              out_valid_reg;
    sample_t           out_sample_reg;
    logic              out_clip_reg;
    logic              out_last_reg;

    logic              en;
    logic              hist_free;
    logic              do_flush;
    logic              do_load;
    logic              issue_last;
    cell_ctrl_t        cell_ctrl;
    sample_t           shift_value;
    sample_t           hist [WIN];
    prod_t             prod [WIN];
    logic signed [ACC_W-1:0] acc;
    logic signed [ACC_W:0]   rnd;
    logic [Q_W-1:0]          q;
    logic                    sat;
    sample_t                 sat_value;

    assign en         = !out_valid_reg || out_ch.ready;
    assign hist_free  = !grp_active_reg || (phase_reg == PH_W'(RATIO - 1));
    assign do_flush   = en && hist_free && (flush_reg != '0);
    assign do_load    = en && hist_free && (flush_reg == '0) && pend_valid_reg;
    assign issue_last = grp_active_reg && grp_final_reg && (phase_reg == PH_W'(RATIO - 1));
    assign fill_inc   = (fill_reg < FILL_W'(EDGE_COPIES + 1)) ? fill_reg + 1'b1 : fill_reg;

    assign cell_ctrl.fill  = do_load && !started_reg;
    assign cell_ctrl.shift = do_flush || (do_load && started_reg);
    assign shift_value     = do_flush ? hist[WIN-1] : pend_sample_reg;

    always_comb
    begin
        pend_valid_next = pend_valid_reg;
        started_next    = started_reg;
        fill_next       = fill_reg;
        flush_next      = flush_reg;
        grp_active_next = grp_active_reg;
        grp_final_next  = grp_final_reg;
        phase_next      = phase_reg;
        if (in_ch.valid && !pend_valid_reg)
        begin
            pend_valid_next = 1'b1;
        end
        if (en && hist_free)
        begin
            grp_active_next = 1'b0;
            grp_final_next  = 1'b0;
            phase_next      = '0;
            if (flush_reg != '0)
            begin
                flush_next      = flush_reg - 1'b1;
                grp_active_next = fill_reg >= FILL_W'(flush_reg);
                grp_final_next  = flush_reg == FL_W'(1);
                if (flush_reg == FL_W'(1))
                begin
                    started_next = 1'b0;
                    fill_next    = '0;
                end
            end
            else if (pend_valid_reg)
            begin
                pend_valid_next = 1'b0;
                started_next    = 1'b1;
                fill_next       = started_reg ? fill_inc : FILL_W'(1);
                grp_active_next = (started_reg ? fill_inc : FILL_W'(1))
                                  == FILL_W'(EDGE_COPIES + 1);
                flush_next      = pend_last_reg ? FL_W'(EDGE_COPIES) : '0;
            end
        end
        else if (en && grp_active_reg)
        begin
            phase_next = phase_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg <= 1'b0;
            started_reg    <= 1'b0;
            fill_reg       <= '0;
            flush_reg      <= '0;
            grp_active_reg <= 1'b0;
            grp_final_reg  <= 1'b0;
            phase_reg      <= '0;
            vld_pipe_reg   <= '0;
            last_pipe_reg  <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            pend_valid_reg <= pend_valid_next;
            started_reg    <= started_next;
            fill_reg       <= fill_next;
            flush_reg      <= flush_next;
            grp_active_reg <= grp_active_next;
            grp_final_reg  <= grp_final_next;
            phase_reg      <= phase_next;
            if (en)
            begin
                vld_pipe_reg  <= {vld_pipe_reg[LVL-1:0], grp_active_reg};
                last_pipe_reg <= {last_pipe_reg[LVL-1:0], issue_last};
                out_valid_reg <= vld_pipe_reg[LVL];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ch.valid && !pend_valid_reg)
        begin
            pend_sample_reg <= in_ch.sample_in;
            pend_last_reg   <= in_ch.last_in;
        end
        if (en)
        begin
            out_sample_reg <= sat_value;
            out_clip_reg   <= sat;
            out_last_reg   <= last_pipe_reg[LVL];
        end
    end

    for (genvar m = 0; m < WIN; m++)
    begin : g_cell
        sample_t nbr;
        if (m == WIN - 1)
        begin : g_tail
            assign nbr = shift_value;
        end
        else
        begin : g_body
            assign nbr = hist[m+1];
        end
        hsi_cell #(
            .RATIO (RATIO),
            .M     (m)
        ) u_cell (
            .clk        (clk),
            .en         (en),
            .ctrl       (cell_ctrl),
            .fill_value (shift_value),
            .nbr_value  (nbr),
            .phase      (phase_reg),
            .hist       (hist[m]),
            .prod       (prod[m])
        );
    end

    hsi_sum_tree #(
        .N     (WIN),
        .IN_W  (PROD_BITS),
        .OUT_W (ACC_W)
    ) u_tree (
        .clk     (clk),
        .en      (en),
        .leaf_in (prod),
        .sum     (acc)
    );

    always_comb
    begin
        rnd = (ACC_W + 1)'(acc) + HALF;
        q   = rnd[ACC_W:COEF_BITS-1];
        sat = !((&q[Q_W-1:SAMPLE_BITS-1]) || !(|q[Q_W-1:SAMPLE_BITS-1]));
        if (sat)
        begin
            sat_value = q[Q_W-1] ? {1'b1, {(SAMPLE_BITS-1){1'b0}}}
                                 : {1'b0, {(SAMPLE_BITS-1){1'b1}}};
        end
        else
        begin
            sat_value = q[SAMPLE_BITS-1:0];
        end
    end

    assign in_ch.ready       = !pend_valid_reg;
    assign out_ch.valid      = out_valid_reg;
    assign out_ch.sample_out = out_sample_reg;
    assign out_ch.clipped    = out_clip_reg;
    assign out_ch.last_out   = out_last_reg;

endmodule

// ===== rtl/hsi_checker.sv =====
// Port-level checks for the x3 interpolator and the bind that attaches them.
// Depends on hsi_pkg and hann_sinc_interpolator_x3.
module hsi_checker (
    input logic             clk,
    input logic             rst_n,
    input logic             in_valid,
    input logic             in_ready,
    input logic             out_valid,
    input logic             out_ready,
    input hsi_pkg::sample_t sample_out,
    input logic             clipped,
    input logic             last_out
);
    import hsi_pkg::*;

    localparam sample_t S_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam sample_t S_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(sample_out) && $stable(last_out))
        else $error("output transaction changed while stalled");

    a_in_buffer: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input buffer took a transaction while full");

    a_clip_rail: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && clipped |-> sample_out == S_MAX || sample_out == S_MIN)
        else $error("saturated output not on a rail");

    a_last_gap: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && last_out |=> !(out_valid && last_out))
        else $error("two consecutive end-of-stream outputs");

endmodule

bind hann_sinc_interpolator_x3 hsi_checker u_hsi_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_ready   (in_ch.ready),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .sample_out (out_ch.sample_out),
    .clipped    (out_ch.clipped),
    .last_out   (out_ch.last_out)
);

// ===== dv/hsi_checker.sv =====
// Transaction checker for the x3 windowed-sinc interpolator: predicts output groups
// from accepted input transactions and compares them with accepted outputs.
// Depends on hsi_pkg.
`timescale 1ns / 100ps

module hsi_tb_checker (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic             in_ready,
    input  hsi_pkg::sample_t in_sample,
    input  logic             in_last,
    input  logic             out_valid,
    input  logic             out_ready,
    input  hsi_pkg::sample_t out_sample,
    input  logic             out_clipped,
    input  logic             out_last,
    output int               mismatch_count,
    output int               pending_results
);
    import hsi_pkg::*;

    localparam int RATIO = RATIO_DEF;
    localparam int EDGE  = EDGE_COPIES_DEF;
    localparam int WIN   = 2 * EDGE + 1;

    localparam int LOWPASS [0:42] = '{
        0, 0, 0, 0, -18, -53, 24, 260, 356, -85, -883, -1068, 166, 2101, 2502,
        -247, -4599, -5847, 306, 13305, 26733, 32440, 26733, 13305, 306, -5847,
        -4599, -247, 2502, 2101, 166, -1068, -883, -85, 356, 260, 24, -53, -18,
        0, 0, 0, 0
    };

    typedef struct {
        sample_t sample;
        logic    clipped;
        logic    last;
    } interp_out_t;

    interp_out_t interp_q[$];
    sample_t     window_hist [WIN];
    int          fill_level;
    bit          in_stream;

    function automatic void shift_window(sample_t x);
        for (int m = 0; m < WIN - 1; m++)
        begin
            window_hist[m] = window_hist[m + 1];
        end
        window_hist[WIN - 1] = x;
    endfunction

    function automatic void filter_group(bit final_group);
        longint      acc;
        longint      y;
        int          j;
        interp_out_t item;
        for (int r = 0; r < RATIO; r++)
        begin
            acc = 0;
            for (int m = 0; m < WIN; m++)
            begin
                j = RATIO * m - r;
                if (j >= 0 && j < TAPS)
                begin
                    acc += longint'(window_hist[m]) * longint'(LOWPASS[j]);
                end
            end
            y = (acc + (longint'(1) <<< (COEF_BITS - 2))) >>> (COEF_BITS - 1);
            item.clipped = 1'b0;
            if (y > 32767)
            begin
                y = 32767;
                item.clipped = 1'b1;
            end
            if (y < -32768)
            begin
                y = -32768;
                item.clipped = 1'b1;
            end
            item.sample = sample_t'(y);
            item.last   = final_group && (r == RATIO - 1);
            interp_q.insert(interp_q.size(), item);
        end
    endfunction

    function automatic void interpolate_sample(sample_t x, logic last);
        if (!in_stream)
        begin
            for (int m = 0; m < WIN; m++)
            begin
                window_hist[m] = x;
            end
            in_stream  = 1'b1;
            fill_level = 0;
        end
        else
        begin
            shift_window(x);
        end
        if (fill_level < EDGE + 1)
        begin
            fill_level++;
        end
        if (fill_level > EDGE)
        begin
            filter_group(1'b0);
        end
        if (last)
        begin
            for (int s = 1; s <= EDGE; s++)
            begin
                shift_window(x);
                if (s + fill_level >= EDGE + 1)
                begin
                    filter_group(s == EDGE);
                end
            end
            in_stream  = 1'b0;
            fill_level = 0;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        interp_out_t want;
        if (!rst_n)
        begin
            interp_q.delete();
            for (int m = 0; m < WIN; m++)
            begin
                window_hist[m] = '0;
            end
            fill_level      = 0;
            in_stream       = 1'b0;
            mismatch_count  = 0;
            pending_results = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (interp_q.size() == 0)
                begin
                    if (mismatch_count < 10)
                    begin
                        $display("%0t: unexpected output sample=%0d clipped=%0b last=%0b",
                                 $realtime, out_sample, out_clipped, out_last);
                    end
                    mismatch_count++;
                end
                else
                begin
                    want = interp_q.pop_front();
                    if (out_sample !== want.sample || out_clipped !== want.clipped ||
                        out_last !== want.last)
                    begin
                        if (mismatch_count < 10)
                        begin
                            $display("%0t: mismatch expected %0d/%0b/%0b got %0d/%0b/%0b",
                                     $realtime, want.sample, want.clipped, want.last,
                                     out_sample, out_clipped, out_last);
                        end
                        mismatch_count++;
                    end
                end
            end
            if (in_valid && in_ready)
            begin
                interpolate_sample(in_sample, in_last);
            end
            pending_results = interp_q.size();
        end
    end

endmodule

// ===== dv/tb.sv =====
// Top of the x3 interpolator testbench: clock, reset, stimulus, output stalls,
// watchdog and verdict. Depends on hsi_pkg, hsi_if, hsi_checker and the block.
`timescale 1ns / 100ps

module tb;
    import hsi_pkg::*;

    localparam int ITEM_TARGET = 410;
    localparam int STALL_LIMIT = 5000;

    logic clk;
    logic rst_n;
    bit   steady;
    int   sent;
    int   idle_cycles;
    int   mismatch_count;
    int   pending_results;

    hsi_in_if  in_ch ();
    hsi_out_if out_ch ();

    hann_sinc_interpolator_x3 u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    hsi_tb_checker u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_ch.valid),
        .in_ready        (in_ch.ready),
        .in_sample       (in_ch.sample_in),
        .in_last         (in_ch.last_in),
        .out_valid       (out_ch.valid),
        .out_ready       (out_ch.ready),
        .out_sample      (out_ch.sample_out),
        .out_clipped     (out_ch.clipped),
        .out_last        (out_ch.last_out),
        .mismatch_count  (mismatch_count),
        .pending_results (pending_results)
    );

    always #5 clk = ~clk;

    always @(negedge clk)
    begin
        out_ch.ready <= steady || ($urandom_range(99) >= 21);
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= STALL_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic send_sample(input sample_t s, input logic last);
        while (!steady && $urandom_range(99) < 21)
        begin
            in_ch.valid <= 1'b0;
            @(negedge clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.sample_in <= s;
        in_ch.last_in   <= last;
        @(posedge clk);
        while (!in_ch.ready)
        begin
            @(posedge clk);
        end
        sent++;
        @(negedge clk);
    endtask

    function automatic sample_t pick_sample(int style, sample_t prev);
        logic [31:0] r;
        int          w;
        r = $urandom;
        case (style)
            1:
            begin
                case ($urandom_range(4))
                    0: return 16'sh7FFF;
                    1: return 16'sh8000;
                    2: return 16'sh0000;
                    3: return 16'shFFFF;
                    default: return 16'sh0001;
                endcase
            end
            2:
            begin
                w = int'(prev) + int'($urandom_range(6000)) - 3000;
                if (w > 32767)
                begin
                    w = 32767;
                end
                if (w < -32768)
                begin
                    w = -32768;
                end
                return sample_t'(w);
            end
            3: return sample_t'(int'($urandom_range(511)) - 256);
            default: return r[15:0];
        endcase
    endfunction

    task automatic send_stream(input int len);
        int      style;
        int      item_style;
        sample_t s;
        style = $urandom_range(4);
        s     = pick_sample(0, 16'sh0000);
        for (int k = 0; k < len; k++)
        begin
            item_style = (style == 4) ? $urandom_range(3) : style;
            s          = pick_sample(item_style, s);
            send_sample(s, k == len - 1);
        end
    endtask

    initial
    begin
        int  len;
        bit  paused;
        clk             = 1'b0;
        rst_n           = 1'b0;
        steady          = 1'b0;
        sent            = 0;
        idle_cycles     = 0;
        paused          = 1'b0;
        in_ch.valid     = 1'b0;
        in_ch.sample_in = '0;
        in_ch.last_in   = 1'b0;
        out_ch.ready    = 1'b0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        send_sample(16'sh7FFF, 1'b1);
        send_sample(16'sh8000, 1'b1);
        send_sample(16'sh7FFF, 1'b0);
        send_sample(16'sh8000, 1'b0);
        send_sample(16'sh7FFF, 1'b1);
        send_sample(16'sh0000, 1'b0);
        send_sample(16'shFFFF, 1'b0);
        send_sample(16'sh0001, 1'b0);
        send_sample(16'sh4000, 1'b0);
        send_sample(16'shC000, 1'b0);
        send_sample(16'sh7FFF, 1'b0);
        send_sample(16'sh8000, 1'b1);
        for (int k = 0; k < 10; k++)
        begin
            send_sample((k % 2 == 0) ? 16'sh7FFF : 16'sh8000, 1'b0);
        end
        send_sample(16'sh0000, 1'b0);
        send_sample(16'shFFFF, 1'b1);

        while (sent < ITEM_TARGET)
        begin
            steady = (sent >= 150 && sent < 230);
            case ($urandom_range(9))
                0, 1: len = $urandom_range(7, 1);
                2:    len = $urandom_range(80, 41);
                default: len = $urandom_range(40, 8);
            endcase
            if (len > ITEM_TARGET - sent)
            begin
                len = ITEM_TARGET - sent;
            end
            send_stream(len);
            if (!paused && sent >= 300)
            begin
                paused = 1'b1;
                in_ch.valid <= 1'b0;
                while (pending_results != 0)
                begin
                    @(negedge clk);
                end
                @(negedge clk);
            end
        end
        steady = 1'b0;
        in_ch.valid   <= 1'b0;
        in_ch.last_in <= 1'b0;

        while (pending_results != 0)
        begin
            @(negedge clk);
        end
        repeat (40) @(negedge clk);
        if (mismatch_count == 0 && pending_results == 0)
        begin
            $display("Testbench completed without errors");
        end
        else
        begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/hsi_pkg.sv
rtl/hsi_if.sv
rtl/hsi_cell.sv
rtl/hsi_sum_tree.sv
rtl/hann_sinc_interpolator_x3.sv
rtl/hsi_checker.sv
dv/hsi_checker.sv
dv/tb.sv
